// ----- sv/matrix_row_column_min_max_unit_macros.svh -----
// Assertion macros used by the checker file of the min/max reduction unit.
`ifndef MATRIX_ROW_COLUMN_MIN_MAX_UNIT_MACROS_SVH
`define MATRIX_ROW_COLUMN_MIN_MAX_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define MRCMM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define MRCMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs during reset.
`define MRCMM_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mrcmm_pkg.sv -----
// Types and constants shared by the min/max reduction unit.
`timescale 1ns / 1ps

package mrcmm_pkg;

  // configuration port geometry
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int COUNT_W     = 7;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_REDUCE_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAKE_MINIMUM = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd3;

  // reduction modes
  typedef enum logic [1:0] {
    MODE_MATRIX = 2'd0,
    MODE_ROW    = 2'd1,
    MODE_COLUMN = 2'd2
  } mode_t;

  // streaming or draining the column burst
  typedef enum logic {
    PH_STREAM = 1'b0,
    PH_DRAIN  = 1'b1
  } phase_t;

  // per-cell control
  typedef struct packed {
    logic update;
    logic first;
    logic take_minimum;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- sv/matrix_row_column_min_max_unit.sv -----
// Top level of the matrix min/max reduction unit.
//
//   channel   signals                                   role
//   element   element_valid/ready, element_value         matrix elements, row-major
//   result    result_valid/ready, extreme_value,         reduced values
//             result_index, last_of_matrix
//   config    cfg_we, cfg_index, cfg_data                register writes, no wait
//
// One element is taken per cycle; whole-matrix and per-row results are registered
// and come out in the cycle after the element that ends them. In per-column mode the last
// element starts a burst of one result per column in use, one per cycle while results
// are taken, shifted out of the column cell chain; no element is taken during the burst.
// Reset is synchronous; no clearing pass. A stalled result holds the output
// register and stops element intake until it is taken.
`timescale 1ns / 1ps

module matrix_row_column_min_max_unit
  import mrcmm_pkg::*;
#(
  parameter int MAX_DIM     = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          element_valid,
  output logic                          element_ready,
  input  logic signed [VALUE_WIDTH-1:0] element_value,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [VALUE_WIDTH-1:0] extreme_value,
  output logic [IDX_W-1:0]              result_index,
  output logic                          last_of_matrix,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  // configuration registers
  logic [1:0]         reduce_mode;
  logic               take_minimum;
  logic [COUNT_W-1:0] row_count;
  logic [COUNT_W-1:0] column_count;

  // position and burst control
  logic [IDX_W-1:0] row_pos;
  logic [IDX_W-1:0] col_pos;
  logic [IDX_W-1:0] drain_idx;
  phase_t           phase;
  phase_t           phase_next;

  logic [COUNT_W-1:0] rows;
  logic [COUNT_W-1:0] cols;
  mode_t              mode;
  logic               out_free;
  logic               accept;
  logic               row_end;
  logic               matrix_end;
  logic               emit_now;
  logic               drain_shift;
  logic               drain_last;

  // cell chain and running accumulator
  cell_ctrl_t                    col_ctrl  [MAX_DIM];
  logic signed [VALUE_WIDTH-1:0] col_value [MAX_DIM];
  logic signed [VALUE_WIDTH-1:0] col_next  [MAX_DIM];
  cell_ctrl_t                    run_ctrl;
  logic signed [VALUE_WIDTH-1:0] run_value;
  logic signed [VALUE_WIDTH-1:0] run_next;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_mode  <= 2'd0;
      take_minimum <= 1'b1;
      row_count    <= COUNT_W'(1);
      column_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REDUCE_MODE:  reduce_mode  <= cfg_data[1:0];
        REG_TAKE_MINIMUM: take_minimum <= cfg_data[0];
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp counts to 1..MAX_DIM, fold the unused mode into whole-matrix
  always_comb begin
    if (row_count == '0) begin
      rows = COUNT_W'(1);
    end else if (int'(row_count) > MAX_DIM) begin
      rows = COUNT_W'(MAX_DIM);
    end else begin
      rows = row_count;
    end
    if (column_count == '0) begin
      cols = COUNT_W'(1);
    end else if (int'(column_count) > MAX_DIM) begin
      cols = COUNT_W'(MAX_DIM);
    end else begin
      cols = column_count;
    end
    case (reduce_mode)
      MODE_ROW:    mode = MODE_ROW;
      MODE_COLUMN: mode = MODE_COLUMN;
      default:     mode = MODE_MATRIX;
    endcase
  end

  assign out_free   = !result_valid || result_ready;
  assign accept     = element_valid && element_ready;
  assign row_end    = (int'(col_pos) + 1) >= int'(cols);
  assign matrix_end = row_end && ((int'(row_pos) + 1) >= int'(rows));
  assign drain_last = (int'(drain_idx) + 1) == int'(cols);
  assign emit_now   = accept && (mode != MODE_COLUMN) &&
                      ((mode == MODE_ROW) ? row_end : matrix_end);

  // phase: next state
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_STREAM: begin
        if (accept && (mode == MODE_COLUMN) && matrix_end) begin
          phase_next = PH_DRAIN;
        end
      end
      PH_DRAIN: begin
        if (drain_shift && drain_last) begin
          phase_next = PH_STREAM;
        end
      end
      default: phase_next = PH_STREAM;
    endcase
  end

  // phase: outputs
  always_comb begin
    case (phase)
      PH_STREAM: begin
        element_ready = out_free;
        drain_shift   = 1'b0;
      end
      PH_DRAIN: begin
        element_ready = 1'b0;
        drain_shift   = out_free;
      end
      default: begin
        element_ready = 1'b0;
        drain_shift   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_STREAM;
    end else begin
      phase <= phase_next;
    end
  end

  // advance the burst index
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_idx <= '0;
    end else if (drain_shift) begin
      drain_idx <= drain_last ? '0 : drain_idx + IDX_W'(1);
    end
  end

  // advance the matrix position; any register write restarts the matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (cfg_we) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_pos <= '0;
        row_pos <= matrix_end ? '0 : row_pos + IDX_W'(1);
      end else begin
        col_pos <= col_pos + IDX_W'(1);
      end
    end
  end

  // column cells: update the addressed column, shift toward cell 0 on drain
  for (genvar i = 0; i < MAX_DIM; i++) begin : g_col
    logic signed [VALUE_WIDTH-1:0] nb;

    if (i < MAX_DIM - 1) begin : g_mid
      assign nb = col_value[i+1];
    end else begin : g_tail
      assign nb = col_value[i];
    end

    always_comb begin
      col_ctrl[i].update       = accept && (mode == MODE_COLUMN) &&
                                 (col_pos == IDX_W'(i));
      col_ctrl[i].first        = (row_pos == '0);
      col_ctrl[i].take_minimum = take_minimum;
      col_ctrl[i].shift        = drain_shift;
    end

    mrcmm_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (col_ctrl[i]),
      .element   (element_value),
      .neighbor  (nb),
      .value     (col_value[i]),
      .value_next(col_next[i])
    );
  end

  // running accumulator for whole-matrix and per-row modes
  always_comb begin
    run_ctrl.update       = accept && (mode != MODE_COLUMN);
    run_ctrl.first        = (mode == MODE_ROW) ? (col_pos == '0) :
                            ((row_pos == '0) && (col_pos == '0));
    run_ctrl.take_minimum = take_minimum;
    run_ctrl.shift        = 1'b0;
  end

  mrcmm_cell #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_run (
    .clk       (clk),
    .ctrl      (run_ctrl),
    .element   (element_value),
    .neighbor  (run_value),
    .value     (run_value),
    .value_next(run_next)
  );

  // output register: valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_now || drain_shift) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (emit_now) begin
      extreme_value  <= run_next;
      result_index   <= (mode == MODE_ROW) ? row_pos : '0;
      last_of_matrix <= matrix_end;
    end else if (drain_shift) begin
      extreme_value  <= col_value[0];
      result_index   <= drain_idx;
      last_of_matrix <= drain_last;
    end
  end

endmodule

// ----- sv/mrcmm_cell.sv -----
// One accumulator cell: compare-and-update, or take the neighbor's value.
`timescale 1ns / 1ps

module mrcmm_cell
  import mrcmm_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  cell_ctrl_t                    ctrl,
  input  logic signed [VALUE_WIDTH-1:0] element,
  input  logic signed [VALUE_WIDTH-1:0] neighbor,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic signed [VALUE_WIDTH-1:0] value_next
);

  logic signed [VALUE_WIDTH-1:0] acc;
  logic signed [VALUE_WIDTH-1:0] acc_next;

  // shift toward the head, or fold in the new element
  always_comb begin
    if (ctrl.shift) begin
      acc_next = neighbor;
    end else if (ctrl.update) begin
      if (ctrl.first) begin
        acc_next = element;
      end else if (ctrl.take_minimum) begin
        acc_next = (element < acc) ? element : acc;
      end else begin
        acc_next = (element > acc) ? element : acc;
      end
    end else begin
      acc_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  assign value      = acc;
  assign value_next = acc_next;

endmodule

// ----- sv/mrcmm_checker.sv -----
// Port-level checks for the matrix min/max reduction unit, bound to the top.
`timescale 1ns / 1ps

`include "matrix_row_column_min_max_unit_macros.svh"

module mrcmm_checker
  import mrcmm_pkg::*;
#(
  parameter int MAX_DIM     = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          element_valid,
  input logic                          element_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic signed [VALUE_WIDTH-1:0] extreme_value,
  input logic [IDX_W-1:0]              result_index,
  input logic                          last_of_matrix
);

  // reset empties the output and opens the element channel
  `MRCMM_ASSERT_RESET(a_reset_clean, rst, !result_valid && element_ready, "result pending after reset")

  // a stalled result holds its payload
  `MRCMM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable({extreme_value, result_index, last_of_matrix}), "stalled result changed")

  // intake stops with an empty output only at the start of a column burst
  `MRCMM_ASSERT_SAME(a_burst_start, !element_ready && !result_valid, $past(element_valid && element_ready), "element refused with nothing pending")

endmodule

bind matrix_row_column_min_max_unit mrcmm_checker #(
  .MAX_DIM(MAX_DIM),
  .VALUE_WIDTH(VALUE_WIDTH)
) u_checker (.*);

// ----- tb/matrix_row_column_min_max_unit_tb.sv -----
// Self-checking testbench for the matrix min/max reduction unit.
`timescale 1ns / 1ps

module matrix_row_column_min_max_unit_tb;
  import mrcmm_pkg::*;

  localparam int MAX_DIM         = 64;
  localparam int VALUE_WIDTH     = 32;
  localparam int IDX_W           = 6;
  localparam int TARGET_ITEMS    = 430;
  localparam int FULL_RATE_ITEMS = 128;
  localparam int SETTLE_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT  = 2000;

  // reduce_mode code the block treats as whole-matrix mode
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic       TAKE_MIN    = 1'b1;
  localparam logic       TAKE_MAX    = 1'b0;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MOST_NEG = 32'sh8000_0000;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MOST_POS = 32'sh7fff_ffff;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [IDX_W-1:0]              index;
    logic                          last;
  } extreme_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          element_valid = 1'b0;
  logic                          element_ready;
  logic signed [VALUE_WIDTH-1:0] element_value = '0;
  logic                          result_valid;
  logic                          result_ready  = 1'b0;
  logic signed [VALUE_WIDTH-1:0] extreme_value;
  logic [IDX_W-1:0]              result_index;
  logic                          last_of_matrix;
  logic                          cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data  = '0;

  // expected results, oldest first
  extreme_result_t pending_extremes[$];

  // predictor copy of the block state and registers
  logic signed [VALUE_WIDTH-1:0] column_acc [MAX_DIM];
  logic signed [VALUE_WIDTH-1:0] running_acc = '0;
  int                            row_pos = 0;
  int                            col_pos = 0;
  logic [1:0]                    cur_mode = MODE_MATRIX;
  logic                          cur_take_min = TAKE_MIN;
  logic [COUNT_W-1:0]            cur_rows = 7'd1;
  logic [COUNT_W-1:0]            cur_cols = 7'd1;

  int  error_count   = 0;
  int  elements_sent = 0;
  int  results_seen  = 0;
  int  writes_done   = 0;
  int  stall_left    = 0;
  int  stuck_cycles  = 0;
  bit  tx_idle_en    = 1'b1;
  bit  rx_idle_en    = 1'b1;

  matrix_row_column_min_max_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .element_valid  (element_valid),
    .element_ready  (element_ready),
    .element_value  (element_value),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .extreme_value  (extreme_value),
    .result_index   (result_index),
    .last_of_matrix (last_of_matrix),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // Clamp a count register to 1..MAX_DIM.
  function automatic int clamp_dim(logic [COUNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_DIM) return MAX_DIM;
    return int'(c);
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] better_of(
      logic signed [VALUE_WIDTH-1:0] acc, logic signed [VALUE_WIDTH-1:0] v);
    if (cur_take_min) return (v < acc) ? v : acc;
    return (v > acc) ? v : acc;
  endfunction

  function automatic void queue_extreme(logic signed [VALUE_WIDTH-1:0] v, int idx,
                                        logic last);
    extreme_result_t res;
    res.value = v;
    res.index = IDX_W'(idx);
    res.last  = last;
    pending_extremes.push_back(res);
  endfunction

  // Fold one element into the predicted state and queue any results it ends.
  function automatic void predict_element(logic signed [VALUE_WIDTH-1:0] v);
    int   rows;
    int   cols;
    int   r;
    int   c;
    logic row_end;
    logic matrix_end;
    rows       = clamp_dim(cur_rows);
    cols       = clamp_dim(cur_cols);
    r          = row_pos;
    c          = col_pos;
    row_end    = (c + 1 >= cols);
    matrix_end = row_end && (r + 1 >= rows);
    if (cur_mode == MODE_COLUMN) begin
      column_acc[c] = (r == 0) ? v : better_of(column_acc[c], v);
      if (matrix_end) begin
        for (int j = 0; j < cols; j++) queue_extreme(column_acc[j], j, j + 1 == cols);
      end
    end else if (cur_mode == MODE_ROW) begin
      running_acc = (c == 0) ? v : better_of(running_acc, v);
      if (row_end) queue_extreme(running_acc, r, matrix_end);
    end else begin
      running_acc = (r == 0 && c == 0) ? v : better_of(running_acc, v);
      if (matrix_end) queue_extreme(running_acc, 0, 1'b1);
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = matrix_end ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] rand_element();
    case ($urandom_range(0, 9))
      0: return VAL_MOST_NEG;
      1: return VAL_MOST_POS;
      // narrow band around zero to force ties
      2, 3: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
    error_count++;
  endtask

  // Write one register; the caller lowers the write enable.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_REDUCE_MODE:  cur_mode     = data[1:0];
      REG_TAKE_MINIMUM: cur_take_min = data[0];
      REG_ROW_COUNT:    cur_rows     = data;
      REG_COLUMN_COUNT: cur_cols     = data;
      default: ;
    endcase
    row_pos = 0;
    col_pos = 0;
    writes_done++;
  endtask

  task automatic configure(logic [1:0] mode, logic take_min, logic [COUNT_W-1:0] rows,
                           logic [COUNT_W-1:0] cols);
    write_reg(REG_REDUCE_MODE, CFG_DATA_W'(mode));
    write_reg(REG_TAKE_MINIMUM, CFG_DATA_W'(take_min));
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COLUMN_COUNT, cols);
    cfg_we <= 1'b0;
  endtask

  // Offer one element and hold it until the transaction completes.
  task automatic send_element(logic signed [VALUE_WIDTH-1:0] v);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      element_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    element_valid <= 1'b1;
    element_value <= v;
    @(posedge clk);
    while (!element_ready) @(posedge clk);
    predict_element(v);
    elements_sent++;
  endtask

  task automatic end_stream();
    element_valid <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline settle.
  task automatic drain_results();
    while (pending_extremes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_matrix();
    repeat (clamp_dim(cur_rows) * clamp_dim(cur_cols)) send_element(rand_element());
  endtask

  // Reset values: whole matrix, minimum, 1 x 1, so every element is a result.
  task automatic check_reset_defaults();
    send_element(VAL_MOST_NEG);
    send_element(VAL_MOST_POS);
    end_stream();
    drain_results();
  endtask

  task automatic check_whole_matrix();
    configure(MODE_MATRIX, TAKE_MAX, 7'd2, 7'd2);
    send_element(VAL_MOST_NEG);
    send_element(-32'sd1);
    send_element(32'sd0);
    send_element(VAL_MOST_POS);
    end_stream();
    drain_results();
  endtask

  task automatic check_row_reduction();
    configure(MODE_ROW, TAKE_MIN, 7'd2, 7'd2);
    send_element(VAL_MOST_POS);
    send_element(VAL_MOST_NEG);
    send_element(32'sh0001_8000);
    send_element(-32'sh0000_8000);
    end_stream();
    drain_results();
  endtask

  task automatic check_column_burst();
    configure(MODE_COLUMN, TAKE_MAX, 7'd2, 7'd3);
    send_element(32'sh5555_5555);
    send_element(VAL_MOST_NEG);
    send_element(32'shffff_0000);
    send_element(32'shaaaa_aaaa);
    send_element(VAL_MOST_POS);
    send_element(32'sh0001_0000);
    end_stream();
    drain_results();
  endtask

  // Mode code 3 acts as whole matrix; zero counts act as one.
  task automatic check_unused_mode_and_zero_counts();
    configure(MODE_UNUSED, TAKE_MIN, 7'd0, 7'd0);
    send_element(32'sh0000_ffff);
    send_element(-32'sd1);
    end_stream();
    drain_results();
  endtask

  // A register write in the middle of a matrix starts it over at (0,0).
  task automatic check_restart_on_write();
    configure(MODE_ROW, TAKE_MAX, 7'd2, 7'd2);
    send_element(VAL_MOST_POS);
    end_stream();
    drain_results();
    write_reg(REG_TAKE_MINIMUM, CFG_DATA_W'(TAKE_MIN));
    cfg_we <= 1'b0;
    send_element(32'sd3);
    send_element(32'sd7);
    send_element(-32'sd2);
    send_element(-32'sd9);
    end_stream();
    drain_results();
  endtask

  // Random settings, mostly whole matrices, some cut short by a restart.
  task automatic run_random_matrices();
    int                 pick;
    int                 total;
    int                 partial;
    logic [1:0]         mode;
    logic               take_min;
    logic [COUNT_W-1:0] rows;
    logic [COUNT_W-1:0] cols;
    while (elements_sent < TARGET_ITEMS - FULL_RATE_ITEMS) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      mode       = 2'($urandom_range(0, 3));
      take_min   = 1'($urandom_range(0, 1));
      pick       = $urandom_range(0, 19);
      if (pick == 0) begin
        rows = COUNT_W'($urandom_range(0, 1));
        cols = COUNT_W'($urandom_range(64, 127));
      end else if (pick == 1) begin
        rows = COUNT_W'($urandom_range(64, 127));
        cols = 7'd1;
      end else if (pick == 2) begin
        rows = 7'd0;
        cols = COUNT_W'($urandom_range(0, 4));
      end else begin
        rows = COUNT_W'($urandom_range(1, 6));
        cols = COUNT_W'($urandom_range(1, 6));
      end
      configure(mode, take_min, rows, cols);
      total = clamp_dim(rows) * clamp_dim(cols);
      repeat ($urandom_range(1, 3)) begin
        if (total > 1 && $urandom_range(0, 7) == 0) begin
          partial = $urandom_range(1, total - 1);
          repeat (partial) send_element(rand_element());
          end_stream();
          drain_results();
          write_reg(REG_TAKE_MINIMUM, CFG_DATA_W'(~cur_take_min));
          cfg_we <= 1'b0;
        end
        send_matrix();
        // hold off the sender until the block has emptied
        if ($urandom_range(0, 5) == 0) begin
          end_stream();
          drain_results();
        end
      end
      end_stream();
      drain_results();
    end
  endtask

  // Largest dimensions at full rate, no idling on either side.
  task automatic run_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    configure(MODE_COLUMN, TAKE_MAX, 7'd1, 7'd127);
    send_matrix();
    end_stream();
    drain_results();
    configure(MODE_ROW, TAKE_MIN, 7'd64, 7'd1);
    send_matrix();
    end_stream();
    drain_results();
  endtask

  // Randomly stall the result channel in bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= (stall_left == 0);
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    extreme_result_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (pending_extremes.size() == 0) begin
        report_mismatch("unexpected result, extreme_value", extreme_value, 0);
      end else begin
        want = pending_extremes.pop_front();
        if (extreme_value !== want.value)
          report_mismatch("extreme_value", extreme_value, want.value);
        if (result_index !== want.index)
          report_mismatch("result_index", result_index, want.index);
        if (last_of_matrix !== want.last)
          report_mismatch("last_of_matrix", last_of_matrix, want.last);
      end
    end
  end

  // End the run if no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (element_valid && element_ready) || (result_valid && result_ready) || cfg_we)
    begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_DIM; i++) column_acc[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_reset_defaults();
    check_whole_matrix();
    check_row_reduction();
    check_column_burst();
    check_unused_mode_and_zero_counts();
    check_restart_on_write();
    run_random_matrices();
    run_full_rate();

    if (pending_extremes.size() != 0)
      report_mismatch("results never received", 0, pending_extremes.size());

    $display("Covered %0d elements, %0d results, %0d register writes", elements_sent,
             results_seen, writes_done);
    $display("Whole, row and column reductions, min and max, counts from 0 past 64");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mrcmm_pkg.sv
sv/mrcmm_cell.sv
sv/matrix_row_column_min_max_unit.sv
sv/mrcmm_checker.sv
tb/matrix_row_column_min_max_unit_tb.sv
